FILE: rtl/core/aufp_pkg.sv
// Shared types, constants and register codes of the audio upsampler and PWM level unit.
package aufp_pkg;

   localparam int TAP_COUNT_DEFAULT = 8;
   localparam int SAMPLE_W          = 16;
   localparam int LEVEL_W           = 10;
   localparam int LEVEL_SHIFT       = 6;
   localparam int FRAC_SHIFT        = 15;
   localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 16'h8000;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_COEF_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_HIGH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_SELECT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MONO_SOURCE   = 3'd4;

   localparam logic [1:0] INTERP_X2 = 2'd1;
   localparam logic [1:0] INTERP_X4 = 2'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type left_sample;
      sample_type right_sample;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] pwm_level;
      logic               channel;
      logic [1:0]         sub_index;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0] coef_taps_low;
      logic [63:0] coef_taps_high;
      logic [1:0]  interp_select;
      logic        filter_enable;
      logic        mono_source;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctrl_type;

endpackage

FILE: rtl/core/aufp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module aufp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/aufp_csr.sv
// Configuration register file behind the APB-style port.
module aufp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [aufp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [aufp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [aufp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output aufp_pkg::cfg_type                   cfg
);

   import aufp_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_strobe;

   // Registers sit on 8-byte boundaries; the low address bits are ignored.
   assign reg_idx   = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (reg_idx)
            REG_COEF_LOW:      cfg_in.coef_taps_low  = pwdata;
            REG_COEF_HIGH:     cfg_in.coef_taps_high = pwdata;
            REG_INTERP_SELECT: cfg_in.interp_select  = pwdata[1:0];
            REG_FILTER_ENABLE: cfg_in.filter_enable  = pwdata[0];
            REG_MONO_SOURCE:   cfg_in.mono_source    = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_COEF_LOW:      prdata = cfg_ff.coef_taps_low;
         REG_COEF_HIGH:     prdata = cfg_ff.coef_taps_high;
         REG_INTERP_SELECT: prdata = {{(CSR_DATA_W-2){1'b0}}, cfg_ff.interp_select};
         REG_FILTER_ENABLE: prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.filter_enable};
         REG_MONO_SOURCE:   prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.mono_source};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/aufp_mac.sv
// Shared multiply-accumulate unit of the FIR with coefficient select and output saturation.
module aufp_mac #(
   parameter int TAP_COUNT = aufp_pkg::TAP_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  aufp_pkg::mac_ctrl_type         ctrl,
   input  logic [$clog2(TAP_COUNT)-1:0]   tap,
   input  logic [63:0]                    coef_taps_low,
   input  logic [63:0]                    coef_taps_high,
   input  aufp_pkg::sample_type           hist_data,
   output aufp_pkg::sample_type           filt_value
);

   import aufp_pkg::*;

   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);

   logic [127:0]              coef_bits;
   sample_type                coef_arr [TAP_COUNT];
   sample_type                coef_sel;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   shifted;
   logic [ACC_W-SAMPLE_W:0]   top_bits;

   assign coef_bits = {coef_taps_high, coef_taps_low};

   for (genvar i = 0; i < TAP_COUNT; i++) begin : g_coef
      assign coef_arr[i] = coef_bits[SAMPLE_W*i +: SAMPLE_W];
   end

   assign coef_sel = coef_arr[tap];

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= coef_sel * hist_data;
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.acc_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // The sum fits 16 bits only when every bit from bit 15 upward matches the sign.
   assign shifted  = acc_ff >>> FRAC_SHIFT;
   assign top_bits = shifted[ACC_W-1:SAMPLE_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         filt_value = shifted[SAMPLE_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         filt_value = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         filt_value = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

endmodule

FILE: rtl/core/audio_upsample_fir_pwm_unit.sv
// Top level: stereo upsampler with optional per-channel FIR, producing PWM duty levels.
//
// Each accepted word holds one signed 16-bit left/right pair and produces 2*F result
// words (F = 1, 2 or 4 from interp_select), phase-major, left before right, with last
// set on the final one. Sub-samples are processed one at a time by a single sequencer:
// unfiltered, a sub-sample passes through S_SUB and S_EMIT; filtered, it also passes through
// S_MAC between them, where every tap is read in turn from the history RAM through its one
// read port and fed to one shared multiply-accumulate unit. S_EMIT waits while rsp_stall
// holds the output register. The history RAM keeps TAP_COUNT entries per channel;
// per-entry valid bits make it read as zero after reset, so no clearing pass is needed.
// A new word is taken while the last result still waits in the output register.
module audio_upsample_fir_pwm_unit #(
   parameter int TAP_COUNT = aufp_pkg::TAP_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  aufp_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output aufp_pkg::rsp_word_type              rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [aufp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [aufp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [aufp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import aufp_pkg::*;

   localparam int TAP_W     = $clog2(TAP_COUNT);
   localparam int CNT_W     = $clog2(TAP_COUNT + 2);
   localparam int RAM_DEPTH = 2 * TAP_COUNT;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SUB  = 2'd1;
   localparam logic [1:0] S_MAC  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   cfg_type       cfg;
   mac_ctrl_type  mac_ctrl;

   logic [1:0]           state_ff, state_in;
   sample_type           cur_ff [2];
   sample_type           cur_in [2];
   sample_type           old_ff [2];
   sample_type           old_in [2];
   logic [TAP_W-1:0]     ptr_ff [2];
   logic [TAP_W-1:0]     ptr_in [2];
   logic [TAP_W-1:0]     p_ff, p_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]           k_ff, k_in;
   logic                 ch_ff, ch_in;
   sample_type           x_ff, x_in;
   logic [RAM_DEPTH-1:0] hist_valid_ff, hist_valid_in;
   logic                 rd_hit_ff, rd_hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   logic                 out_free;
   logic [1:0]           last_k;
   logic                 is_last;
   sample_type           old_sel, cur_sel;
   logic signed [16:0]   sum_mid, sum_q1, sum_q3;
   sample_type           mid, q1, q3, sub_value;
   sample_type           filt_value, out_value;
   logic [SAMPLE_W-1:0]  biased;
   logic [TAP_W:0]       idx_sum;
   logic [TAP_W-1:0]     idx;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [SAMPLE_W-1:0]  ram_rd_data;
   sample_type           hist_data;
   logic [TAP_W-1:0]     mul_tap;
   logic [CNT_W-1:0]     cnt_dec;

   aufp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   aufp_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (x_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   aufp_mac #(
      .TAP_COUNT (TAP_COUNT)
   ) u_mac (
      .clock          (clock),
      .ctrl           (mac_ctrl),
      .tap            (mul_tap),
      .coef_taps_low  (cfg.coef_taps_low),
      .coef_taps_high (cfg.coef_taps_high),
      .hist_data      (hist_data),
      .filt_value     (filt_value)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      case (cfg.interp_select)
         INTERP_X2: last_k = 2'd1;
         INTERP_X4: last_k = 2'd3;
         default:   last_k = 2'd0;
      endcase
   end

   assign is_last = (k_ff == last_k) & ch_ff;

   // Interpolated sub-sample of the current phase; midpoints are floor averages.
   assign old_sel = old_ff[ch_ff];
   assign cur_sel = cur_ff[ch_ff];
   assign sum_mid = {old_sel[SAMPLE_W-1], old_sel} + {cur_sel[SAMPLE_W-1], cur_sel};
   assign mid     = sum_mid[16:1];
   assign sum_q1  = {old_sel[SAMPLE_W-1], old_sel} + {mid[SAMPLE_W-1], mid};
   assign sum_q3  = {mid[SAMPLE_W-1], mid} + {cur_sel[SAMPLE_W-1], cur_sel};
   assign q1      = sum_q1[16:1];
   assign q3      = sum_q3[16:1];

   always_comb begin
      case (cfg.interp_select)
         INTERP_X2: sub_value = (k_ff == 2'd0) ? mid : cur_sel;
         INTERP_X4: begin
            case (k_ff)
               2'd0:    sub_value = q1;
               2'd1:    sub_value = mid;
               2'd2:    sub_value = q3;
               default: sub_value = cur_sel;
            endcase
         end
         default:   sub_value = cur_sel;
      endcase
   end

   // History tap address: (pointer + tap) mod TAP_COUNT within the channel's half.
   assign idx_sum     = {1'b0, p_ff} + {1'b0, cnt_ff[TAP_W-1:0]};
   assign idx         = (idx_sum >= (TAP_W+1)'(TAP_COUNT)) ?
                        TAP_W'(idx_sum - (TAP_W+1)'(TAP_COUNT)) : idx_sum[TAP_W-1:0];
   assign ram_rd_addr = ch_ff ? ADDR_W'(TAP_COUNT) + ADDR_W'(idx) : ADDR_W'(idx);
   assign ram_rd_en   = (state_ff == S_MAC) && (cnt_ff < CNT_W'(TAP_COUNT));
   assign ram_wr_en   = (state_ff == S_SUB) && cfg.filter_enable;
   assign ram_wr_addr = ch_ff ? ADDR_W'(TAP_COUNT) + ADDR_W'(ptr_ff[ch_ff])
                              : ADDR_W'(ptr_ff[ch_ff]);
   assign hist_data   = rd_hit_ff ? ram_rd_data : '0;

   assign cnt_dec  = cnt_ff - CNT_W'(1);
   assign mul_tap  = cnt_dec[TAP_W-1:0];

   always_comb begin
      mac_ctrl.clear  = ram_wr_en;
      mac_ctrl.mul_en = (state_ff == S_MAC) && (cnt_ff >= CNT_W'(1))
                        && (cnt_ff <= CNT_W'(TAP_COUNT));
      mac_ctrl.acc_en = (state_ff == S_MAC) && (cnt_ff >= CNT_W'(2));
   end

   assign out_value = cfg.filter_enable ? filt_value : x_ff;
   assign biased    = out_value + SAMPLE_OFFSET;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      old_in        = old_ff;
      ptr_in        = ptr_ff;
      p_in          = p_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      ch_in         = ch_ff;
      x_in          = x_ff;
      hist_valid_in = hist_valid_ff;
      rd_hit_in     = hist_valid_ff[ram_rd_addr];
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               old_in    = cur_ff;
               cur_in[0] = req_data.left_sample;
               cur_in[1] = cfg.mono_source ? req_data.left_sample : req_data.right_sample;
               k_in      = 2'd0;
               ch_in     = 1'b0;
               state_in  = S_SUB;
            end
         end
         S_SUB: begin
            x_in = sub_value;
            if (cfg.filter_enable) begin
               hist_valid_in[ram_wr_addr] = 1'b1;
               p_in          = ptr_ff[ch_ff];
               ptr_in[ch_ff] = (ptr_ff[ch_ff] == '0) ? TAP_W'(TAP_COUNT - 1)
                                                      : ptr_ff[ch_ff] - TAP_W'(1);
               cnt_in        = '0;
               state_in      = S_MAC;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_MAC: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TAP_COUNT + 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.pwm_level = biased[SAMPLE_W-1:LEVEL_SHIFT];
               rsp_data_in.channel   = ch_ff;
               rsp_data_in.sub_index = k_ff;
               rsp_data_in.last      = is_last;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SUB;
                  ch_in    = ~ch_ff;
                  if (ch_ff) begin
                     k_in = k_ff + 2'd1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '{default: '0};
         ptr_ff        <= '{default: '0};
         cnt_ff        <= '0;
         k_ff          <= '0;
         ch_ff         <= 1'b0;
         hist_valid_ff <= '0;
         rd_hit_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         ptr_ff        <= ptr_in;
         cnt_ff        <= cnt_in;
         k_ff          <= k_in;
         ch_ff         <= ch_in;
         hist_valid_ff <= hist_valid_in;
         rd_hit_ff     <= rd_hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff      <= old_in;
      p_ff        <= p_in;
      x_ff        <= x_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/sv/aufp_level_checker.sv
`timescale 1ns / 1ps
// Checker that snoops the register port and both word channels and predicts level words.
module aufp_level_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  aufp_pkg::req_word_type            req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  aufp_pkg::rsp_word_type            rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [aufp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [aufp_pkg::CSR_DATA_W-1:0]   pwdata,
   output int                                level_errors,
   output int                                levels_pending
);
   import aufp_pkg::*;

   localparam int TAPS = TAP_COUNT_DEFAULT;

   logic [63:0] coef_low;
   logic [63:0] coef_high;
   logic [1:0]  interp_sel;
   logic        filter_on;
   logic        mono_on;

   int prev_sample [2];
   int tap_history [2][TAPS];
   int write_pos [2];
   rsp_word_type expected_levels [$];
   int error_total = 0;

   task automatic report_mismatch(input string what);
      $display("%0t ns: level word error: %s", $time, what);
      error_total++;
   endtask

   function automatic int coefficient(input int t);
      logic [63:0]        bank;
      logic signed [15:0] c;
      bank = (t < 4) ? coef_low : coef_high;
      c = bank[16*(t%4) +: 16];
      return int'(c);
   endfunction

   // The new sub-sample lands at the write position, tap l reads position + l, and the
   // position then steps down by one with wrap-around.
   function automatic int filter_sample(input int ch, input int x);
      int     p;
      longint acc;
      p = write_pos[ch];
      tap_history[ch][p] = x;
      acc = 0;
      for (int l = 0; l < TAPS; l++) begin
         acc += longint'(coefficient(l)) * longint'(tap_history[ch][(p + l) % TAPS]);
      end
      write_pos[ch] = (p == 0) ? TAPS - 1 : p - 1;
      acc = acc >>> FRAC_SHIFT;
      if (acc > 32767) begin
         acc = 32767;
      end else if (acc < -32768) begin
         acc = -32768;
      end
      return int'(acc);
   endfunction

   function automatic int midpoint(input int a, input int b);
      return (a + b) >>> 1;
   endfunction

   task automatic predict_levels(input req_word_type w);
      int           cur [2];
      int           sub [2][4];
      int           factor;
      int           mid;
      int           lvl;
      rsp_word_type r;
      cur[0] = int'($signed(w.left_sample));
      cur[1] = mono_on ? cur[0] : int'($signed(w.right_sample));
      factor = (interp_sel == INTERP_X2) ? 2 : (interp_sel == INTERP_X4) ? 4 : 1;
      for (int ch = 0; ch < 2; ch++) begin
         mid = midpoint(prev_sample[ch], cur[ch]);
         if (factor == 1) begin
            sub[ch][0] = cur[ch];
         end else if (factor == 2) begin
            sub[ch][0] = mid;
            sub[ch][1] = cur[ch];
         end else begin
            sub[ch][0] = midpoint(prev_sample[ch], mid);
            sub[ch][1] = mid;
            sub[ch][2] = midpoint(mid, cur[ch]);
            sub[ch][3] = cur[ch];
         end
         if (filter_on) begin
            for (int k = 0; k < factor; k++) begin
               sub[ch][k] = filter_sample(ch, sub[ch][k]);
            end
         end
         prev_sample[ch] = cur[ch];
      end
      for (int k = 0; k < factor; k++) begin
         for (int ch = 0; ch < 2; ch++) begin
            lvl = (sub[ch][k] + int'(SAMPLE_OFFSET)) >>> LEVEL_SHIFT;
            r.pwm_level = lvl[LEVEL_W-1:0];
            r.channel   = ch[0];
            r.sub_index = k[1:0];
            r.last      = (k == factor - 1) && (ch == 1);
            expected_levels.push_back(r);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         coef_low   = '0;
         coef_high  = '0;
         interp_sel = '0;
         filter_on  = 1'b0;
         mono_on    = 1'b0;
         for (int ch = 0; ch < 2; ch++) begin
            prev_sample[ch] = 0;
            write_pos[ch]   = 0;
            for (int t = 0; t < TAPS; t++) begin
               tap_history[ch][t] = 0;
            end
         end
         expected_levels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3 +: CSR_IDX_W])
               REG_COEF_LOW:      coef_low   = pwdata;
               REG_COEF_HIGH:     coef_high  = pwdata;
               REG_INTERP_SELECT: interp_sel = pwdata[1:0];
               REG_FILTER_ENABLE: filter_on  = pwdata[0];
               REG_MONO_SOURCE:   mono_on    = pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_levels.size() == 0) begin
               report_mismatch($sformatf("word %h arrived with nothing expected", got));
            end else begin
               want = expected_levels.pop_front();
               if (got.pwm_level !== want.pwm_level) begin
                  report_mismatch($sformatf("pwm_level %0d, expected %0d (ch %0d, k %0d)",
                     got.pwm_level, want.pwm_level, want.channel, want.sub_index));
               end
               if (got.channel !== want.channel) begin
                  report_mismatch($sformatf("channel %0d, expected %0d (k %0d)",
                     got.channel, want.channel, want.sub_index));
               end
               if (got.sub_index !== want.sub_index) begin
                  report_mismatch($sformatf("sub_index %0d, expected %0d (ch %0d)",
                     got.sub_index, want.sub_index, want.channel));
               end
               if (got.last !== want.last) begin
                  report_mismatch($sformatf("last %0d, expected %0d (ch %0d, k %0d)",
                     got.last, want.last, want.channel, want.sub_index));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_levels(req_data);
         end
      end
      levels_pending <= expected_levels.size();
      level_errors   <= error_total;
   end

endmodule

FILE: tb/sv/audio_upsample_fir_pwm_unit_test.sv
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, register setup, sample stimulus and the final verdict.
module audio_upsample_fir_pwm_unit_test;
   import aufp_pkg::*;

   localparam logic [1:0] INTERP_X1     = 2'd0;
   localparam logic [1:0] INTERP_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_word_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_word_type          rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int level_errors;
   int levels_pending;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   audio_upsample_fir_pwm_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   aufp_level_checker level_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .level_errors   (level_errors),
      .levels_pending (levels_pending)
   );

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [63:0] coefs_lo, input logic [63:0] coefs_hi,
                                input logic [1:0] interp, input logic filt,
                                input logic mono);
      write_csr(REG_COEF_LOW, coefs_lo);
      write_csr(REG_COEF_HIGH, coefs_hi);
      write_csr(REG_INTERP_SELECT, {62'd0, interp});
      write_csr(REG_FILTER_ENABLE, {63'd0, filt});
      write_csr(REG_MONO_SOURCE, {63'd0, mono});
   endtask

   task automatic send_pair(input int left, input int right);
      req_word_type w;
      w.left_sample  = left[15:0];
      w.right_sample = right[15:0];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // The extra edge lets the checker count the word accepted at the current edge.
   task automatic drain_levels();
      req_valid <= 1'b0;
      @(posedge clock);
      while (levels_pending != 0) @(posedge clock);
   endtask

   function automatic int random_sample();
      logic [15:0] v;
      v = 16'($urandom());
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 32767 : -32768;
         1: return int'($urandom_range(512)) - 256;
         default: return int'($signed(v));
      endcase
   endfunction

   // Mostly modest coefficients so that the filter output is not always pinned.
   function automatic logic [63:0] random_coefs();
      logic [63:0] c;
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(3) == 0) begin
            c[16*i +: 16] = 16'($urandom());
         end else begin
            c[16*i +: 16] = 16'($urandom_range(8192)) - 16'd4096;
         end
      end
      return c;
   endfunction

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one phase, no filter, independent channels.
      send_pair(32767, -32768);
      send_pair(-32768, 32767);
      send_pair(0, -1);
      send_pair(-1, 0);
      drain_levels();

      // Two phases with the left sample copied to the right; odd negative sums round down.
      apply_setting(64'd0, 64'd0, INTERP_X2, 1'b0, 1'b1);
      send_pair(32767, 1234);
      send_pair(-32768, -77);
      send_pair(-3, 5);
      drain_levels();

      apply_setting(64'd0, 64'd0, INTERP_UNUSED, 1'b0, 1'b0);
      send_pair(100, -101);
      drain_levels();

      // Four phases through the filter, enough sub-samples to wrap the history.
      apply_setting(64'h1000_E000_4000_7FFF, 64'h8001_0100_F000_0800, INTERP_X4, 1'b1, 1'b0);
      send_pair(32767, -32768);
      send_pair(-32768, 32767);
      send_pair(21845, -21846);
      drain_levels();

      // With the filter off the history must stay as it was.
      apply_setting(64'h1000_E000_4000_7FFF, 64'h8001_0100_F000_0800, INTERP_X4, 1'b0, 1'b0);
      send_pair(-1234, 4321);
      drain_levels();
      apply_setting(64'h1000_E000_4000_7FFF, 64'h8001_0100_F000_0800, INTERP_X4, 1'b1, 1'b0);
      send_pair(555, -555);
      drain_levels();

      // Full-scale coefficients drive the filter sum into both saturation limits.
      apply_setting(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, INTERP_X1, 1'b1, 1'b0);
      send_pair(32767, -32768);
      send_pair(32767, -32768);
      drain_levels();
      apply_setting(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, INTERP_X1, 1'b1, 1'b0);
      send_pair(32767, -32768);
      send_pair(-32768, 32767);
      drain_levels();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         apply_setting(random_coefs(), random_coefs(), 2'($urandom_range(3)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
         for (int n = 0; n < 13; n++) begin
            send_pair(random_sample(), random_sample());
            if (phase == 2 && n == 6) begin
               drain_levels();
            end
         end
         drain_levels();
      end

      repeat (100) @(posedge clock);
      @(negedge clock);
      if (level_errors == 0) begin
         $display("audio_upsample_fir_pwm_unit: match");
      end else begin
         $display("audio_upsample_fir_pwm_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("audio_upsample_fir_pwm_unit: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/aufp_pkg.sv
rtl/core/aufp_ram.sv
rtl/core/aufp_csr.sv
rtl/core/aufp_mac.sv
rtl/core/audio_upsample_fir_pwm_unit.sv
tb/sv/aufp_level_checker.sv
tb/sv/audio_upsample_fir_pwm_unit_test.sv
